### src/pmw_pkg.sv
// Shared types, constants and codes for the minimum spanning tree weight block.
package pmw_pkg;

  localparam int MaxVertices = 64;
  localparam int WeightBits  = 16;
  localparam int VtxBits     = $clog2(MaxVertices);
  localparam int CntBits     = VtxBits + 1;
  localparam int AddrBits    = 2 * VtxBits;
  localparam int TotalBits   = 22;
  localparam int CfgIdxBits  = 1;
  localparam int CfgDataBits = 16;

  localparam logic [TotalBits-1:0]  TotalMax      = '1;
  localparam logic [WeightBits-1:0] DefaultNoEdge = WeightBits'(1000);
  localparam logic [CntBits-1:0]    MaxVtxCount   = CntBits'(MaxVertices);

  // Configuration register indexes.
  localparam logic [CfgIdxBits-1:0] CfgVertexCount = 1'b0;
  localparam logic [CfgIdxBits-1:0] CfgNoEdge      = 1'b1;

  // One heap slot: key and the vertex that owns it.
  typedef struct packed {
    logic [WeightBits-1:0] key;
    logic [VtxBits-1:0]    vtx;
  } heap_ent_t;

  // Commands from the controller to the datapath.
  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LOAD,
    OP_OUT,
    OP_INIT,
    OP_INIT_WR,
    OP_BUILD_SET,
    OP_BUILD_DEC,
    OP_SD_SET_BLD,
    OP_SD_SET_ROOT,
    OP_SD_RDL,
    OP_SD_RDR,
    OP_SD_PICK,
    OP_SD_CMP,
    OP_SD_SWAP,
    OP_EX_RD0,
    OP_EX_RDL,
    OP_EX_WR0,
    OP_EX_WRL,
    OP_EX_RDMIN,
    OP_EX_ADD,
    OP_EX_MUL,
    OP_RX_RD,
    OP_RX_EDGE,
    OP_RX_UPD,
    OP_FIN_RD,
    OP_FIN_ADD
  } dp_op_e;

  // Controller states.
  typedef enum logic [4:0] {
    ST_LOAD,
    ST_INIT,
    ST_INIT_WR,
    ST_BUILD_SET,
    ST_BUILD_CHK,
    ST_BUILD_DEC,
    ST_SD0,
    ST_SD1,
    ST_SD2,
    ST_SD3,
    ST_SD4,
    ST_LOOP_CHK,
    ST_EX0,
    ST_EX1,
    ST_EX2,
    ST_EX3,
    ST_EX4,
    ST_EX5,
    ST_EX6,
    ST_RX0,
    ST_RX1,
    ST_RX2,
    ST_FIN0,
    ST_FIN1,
    ST_DONE
  } ctrl_state_e;

  // Status flags from the datapath to the controller.
  typedef struct packed {
    logic init_last;
    logic k_zero;
    logic sd_leaf;
    logic swap;
    logic relax_last;
    logic loop_more;
    logic out_free;
  } dp_status_t;

endpackage

### src/prim_mst_weight.sv
// Top level of the minimum spanning tree weight block.
// Matrix words load at one per cycle, row-major, into a 4096-word matrix
// memory; the word flagged last_entry starts the computation and the input
// then stalls until the total has been handed to the output register. The
// computation runs Prim's method over a binary min-heap held in a 64-entry
// memory with one registered read and one write per cycle. After each
// extraction, the row scan lowers the keys of the vertices left in the
// heap, and the heap rebuild then sifts down each internal node in turn.
// The result word is held until taken, while the next matrix loads.
module prim_mst_weight (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pmw_pkg::CfgIdxBits-1:0]      cfg_idx_i,
  input  logic [pmw_pkg::CfgDataBits-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [pmw_pkg::WeightBits-1:0]      weight_i,
  input  logic                                last_entry_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [pmw_pkg::TotalBits-1:0]       total_weight_o
);
  import pmw_pkg::*;

  dp_op_e     op;
  dp_status_t status;

  // Sequencer.
  pmw_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .last_entry_i (last_entry_i),
    .in_stall_o   (in_stall_o),
    .status_i     (status),
    .op_o         (op)
  );

  // Datapath and storage.
  pmw_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .weight_i       (weight_i),
    .last_entry_i   (last_entry_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .total_weight_o (total_weight_o),
    .op_i           (op),
    .status_o       (status)
  );

endmodule

### src/pmw_ctrl.sv
// Sequencer that steps the load, heap build, extraction, relaxation, final sum and output phases.
module pmw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                last_entry_i,
  output logic                in_stall_o,
  input  pmw_pkg::dp_status_t status_i,
  output pmw_pkg::dp_op_e     op_o
);
  import pmw_pkg::*;

  ctrl_state_e state_q, state_d;
  // Set while a sift-down was called from the heap build, clear from extraction.
  logic        ret_bld_q, ret_bld_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      ret_bld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ret_bld_q <= ret_bld_d;
    end
  end

  assign in_stall_o = (state_q != ST_LOAD);

  // Next state and datapath command.
  always_comb begin
    state_d   = state_q;
    ret_bld_d = ret_bld_q;
    op_o      = OP_IDLE;
    unique case (state_q)
      ST_LOAD: begin
        if (in_valid_i) begin
          op_o = OP_LOAD;
          if (last_entry_i) state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        op_o    = OP_INIT;
        state_d = ST_INIT_WR;
      end
      ST_INIT_WR: begin
        op_o = OP_INIT_WR;
        if (status_i.init_last) state_d = ST_BUILD_SET;
      end
      ST_BUILD_SET: begin
        op_o    = OP_BUILD_SET;
        state_d = ST_BUILD_CHK;
      end
      ST_BUILD_CHK: begin
        if (status_i.k_zero) begin
          state_d = ST_LOOP_CHK;
        end else begin
          op_o      = OP_SD_SET_BLD;
          ret_bld_d = 1'b1;
          state_d   = ST_SD0;
        end
      end
      ST_BUILD_DEC: begin
        op_o    = OP_BUILD_DEC;
        state_d = ST_BUILD_CHK;
      end
      ST_SD0: begin
        if (status_i.sd_leaf) begin
          state_d = ret_bld_q ? ST_BUILD_DEC : ST_EX4;
        end else begin
          op_o    = OP_SD_RDL;
          state_d = ST_SD1;
        end
      end
      ST_SD1: begin
        op_o    = OP_SD_RDR;
        state_d = ST_SD2;
      end
      ST_SD2: begin
        op_o    = OP_SD_PICK;
        state_d = ST_SD3;
      end
      ST_SD3: begin
        op_o    = OP_SD_CMP;
        state_d = status_i.swap ? ST_SD4 : ST_SD0;
      end
      ST_SD4: begin
        op_o    = OP_SD_SWAP;
        state_d = ST_SD0;
      end
      ST_LOOP_CHK: begin
        state_d = status_i.loop_more ? ST_EX0 : ST_FIN0;
      end
      ST_EX0: begin
        op_o    = OP_EX_RD0;
        state_d = ST_EX1;
      end
      ST_EX1: begin
        op_o    = OP_EX_RDL;
        state_d = ST_EX2;
      end
      ST_EX2: begin
        op_o    = OP_EX_WR0;
        state_d = ST_EX3;
      end
      ST_EX3: begin
        op_o      = OP_EX_WRL;
        ret_bld_d = 1'b0;
        state_d   = ST_SD0;
      end
      ST_EX4: begin
        op_o    = OP_EX_RDMIN;
        state_d = ST_EX5;
      end
      ST_EX5: begin
        op_o    = OP_EX_ADD;
        state_d = ST_EX6;
      end
      ST_EX6: begin
        op_o    = OP_EX_MUL;
        state_d = ST_RX0;
      end
      ST_RX0: begin
        op_o    = OP_RX_RD;
        state_d = ST_RX1;
      end
      ST_RX1: begin
        op_o    = OP_RX_EDGE;
        state_d = ST_RX2;
      end
      ST_RX2: begin
        op_o    = OP_RX_UPD;
        state_d = status_i.relax_last ? ST_BUILD_SET : ST_RX0;
      end
      ST_FIN0: begin
        op_o    = OP_FIN_RD;
        state_d = ST_FIN1;
      end
      ST_FIN1: begin
        op_o    = OP_FIN_ADD;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          op_o    = OP_OUT;
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

endmodule

### src/pmw_dp.sv
// Datapath: matrix memory, heap memory, counters, total and result register.
module pmw_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pmw_pkg::CfgIdxBits-1:0]      cfg_idx_i,
  input  logic [pmw_pkg::CfgDataBits-1:0]     cfg_data_i,
  input  logic [pmw_pkg::WeightBits-1:0]      weight_i,
  input  logic                                last_entry_i,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic [pmw_pkg::TotalBits-1:0]       total_weight_o,
  input  pmw_pkg::dp_op_e                     op_i,
  output pmw_pkg::dp_status_t                 status_o
);
  import pmw_pkg::*;

  // Configuration.
  logic [CntBits-1:0]    vc_q;
  logic [WeightBits-1:0] ne_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= MaxVtxCount;
      ne_q <= DefaultNoEdge;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgVertexCount: vc_q <= cfg_data_i[CntBits-1:0];
        CfgNoEdge:      ne_q <= cfg_data_i[WeightBits-1:0];
        default:        ;
      endcase
    end
  end

  // Memories.
  logic [WeightBits-1:0] edge_mem [2**AddrBits];
  heap_ent_t             heap_mem [MaxVertices];

  logic                  edge_we;
  logic [AddrBits-1:0]   edge_waddr, edge_raddr;
  logic [WeightBits-1:0] edge_rd_q;
  logic                  heap_we;
  logic [VtxBits-1:0]    heap_waddr, heap_raddr;
  heap_ent_t             heap_wdata, heap_rd_q;

  always_ff @(posedge clk_i) begin
    if (edge_we) edge_mem[edge_waddr] <= weight_i;
    edge_rd_q <= edge_mem[edge_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (heap_we) heap_mem[heap_waddr] <= heap_wdata;
    heap_rd_q <= heap_mem[heap_raddr];
  end

  // Working registers.
  logic [AddrBits-1:0]    load_pos_q;
  logic [CntBits-1:0]     n_q, cnt_q, k_q, size_q, i_q;
  logic [VtxBits-1:0]     pos_q, cidx_q, v_q;
  heap_ent_t              left_q, child_q, par_q, a_q, ent_q;
  logic [AddrBits-1:0]    vn_q;
  logic [TotalBits-1:0]   total_q;
  logic                   out_valid_q;
  logic [TotalBits-1:0]   out_q;

  // Child positions of the current sift-down node.
  logic [CntBits-1:0]     lidx;
  logic [CntBits:0]       ridx;
  logic                   right_in;
  logic                   pick_right;
  logic [CntBits-1:0]     n_clamp;
  logic [CntBits-1:0]     i_m1;
  logic [TotalBits:0]     sum;
  logic [TotalBits-1:0]   sum_sat;
  logic [2*VtxBits:0]     vn_full;

  assign lidx       = {pos_q, 1'b1};
  assign ridx       = {1'b0, lidx} + (CntBits+1)'(1);
  assign right_in   = (ridx < {1'b0, size_q});
  assign pick_right = right_in && (heap_rd_q.key < left_q.key);
  assign i_m1       = i_q - CntBits'(1);
  assign sum        = {1'b0, total_q} + (TotalBits+1)'(heap_rd_q.key);
  assign sum_sat    = sum[TotalBits] ? TotalMax : sum[TotalBits-1:0];
  assign vn_full    = (2*VtxBits+1)'(v_q) * (2*VtxBits+1)'(n_q);

  // Vertex count clamped into the supported range.
  always_comb begin
    if (vc_q == '0) begin
      n_clamp = CntBits'(1);
    end else if (vc_q > MaxVtxCount) begin
      n_clamp = MaxVtxCount;
    end else begin
      n_clamp = vc_q;
    end
  end

  // Status back to the controller.
  assign status_o.init_last  = (cnt_q == n_q - CntBits'(1));
  assign status_o.k_zero     = (k_q == '0);
  assign status_o.sd_leaf    = (lidx >= size_q);
  assign status_o.swap       = (heap_rd_q.key > child_q.key);
  assign status_o.relax_last = (cnt_q + CntBits'(1) == i_q);
  assign status_o.loop_more  = (i_q >= CntBits'(2));
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

  // Memory addressing per command.
  always_comb begin
    edge_we    = 1'b0;
    edge_waddr = load_pos_q;
    edge_raddr = vn_q + AddrBits'(heap_rd_q.vtx);
    heap_we    = 1'b0;
    heap_waddr = pos_q;
    heap_wdata = child_q;
    heap_raddr = pos_q;
    unique case (op_i)
      OP_LOAD: edge_we = 1'b1;
      OP_INIT_WR: begin
        heap_we        = 1'b1;
        heap_waddr     = cnt_q[VtxBits-1:0];
        heap_wdata.key = (cnt_q == '0) ? '0 : ne_q;
        heap_wdata.vtx = cnt_q[VtxBits-1:0];
      end
      OP_SD_RDL:  heap_raddr = lidx[VtxBits-1:0];
      OP_SD_RDR:  heap_raddr = ridx[VtxBits-1:0];
      OP_SD_PICK: heap_raddr = pos_q;
      OP_SD_CMP: begin
        heap_we    = status_o.swap;
        heap_waddr = pos_q;
        heap_wdata = child_q;
      end
      OP_SD_SWAP: begin
        heap_we    = 1'b1;
        heap_waddr = cidx_q;
        heap_wdata = par_q;
      end
      OP_EX_RD0: heap_raddr = '0;
      OP_EX_RDL: heap_raddr = i_m1[VtxBits-1:0];
      OP_EX_WR0: begin
        heap_we    = 1'b1;
        heap_waddr = '0;
        heap_wdata = heap_rd_q;
      end
      OP_EX_WRL: begin
        heap_we    = 1'b1;
        heap_waddr = i_m1[VtxBits-1:0];
        heap_wdata = a_q;
      end
      OP_EX_RDMIN: heap_raddr = size_q[VtxBits-1:0];
      OP_RX_RD:    heap_raddr = cnt_q[VtxBits-1:0];
      OP_RX_UPD: begin
        heap_we        = (edge_rd_q < ne_q) && (ent_q.key > edge_rd_q);
        heap_waddr     = cnt_q[VtxBits-1:0];
        heap_wdata.key = edge_rd_q;
        heap_wdata.vtx = ent_q.vtx;
      end
      OP_FIN_RD: heap_raddr = '0;
      default: ;
    endcase
  end

  // Control counters and load position.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_pos_q  <= '0;
      out_valid_q <= 1'b0;
      total_q     <= '0;
      n_q         <= '0;
      cnt_q       <= '0;
      k_q         <= '0;
      size_q      <= '0;
      i_q         <= '0;
      pos_q       <= '0;
    end else begin
      if (op_i == OP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (op_i)
        OP_LOAD: load_pos_q <= last_entry_i ? '0 : load_pos_q + AddrBits'(1);
        OP_INIT: begin
          n_q     <= n_clamp;
          size_q  <= n_clamp;
          i_q     <= n_clamp;
          cnt_q   <= '0;
          total_q <= '0;
        end
        OP_INIT_WR:     cnt_q <= cnt_q + CntBits'(1);
        OP_BUILD_SET:   k_q <= size_q >> 1;
        OP_BUILD_DEC:   k_q <= k_q - CntBits'(1);
        OP_SD_SET_BLD:  pos_q <= k_q[VtxBits-1:0] - VtxBits'(1);
        OP_SD_SET_ROOT: pos_q <= '0;
        OP_SD_CMP:      pos_q <= cidx_q;
        OP_SD_SWAP:     pos_q <= cidx_q;
        OP_EX_RD0:      size_q <= i_m1;
        OP_EX_WRL:      pos_q <= '0;
        OP_EX_ADD: begin
          total_q <= sum_sat;
          i_q     <= i_m1;
        end
        OP_EX_MUL:      cnt_q <= '0;
        OP_RX_UPD:      cnt_q <= cnt_q + CntBits'(1);
        OP_FIN_ADD:     total_q <= sum_sat;
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    unique case (op_i)
      OP_SD_RDR: left_q <= heap_rd_q;
      OP_SD_PICK: begin
        child_q <= pick_right ? heap_rd_q : left_q;
        cidx_q  <= pick_right ? ridx[VtxBits-1:0] : lidx[VtxBits-1:0];
      end
      OP_SD_CMP:  par_q <= heap_rd_q;
      OP_EX_RDL:  a_q <= heap_rd_q;
      OP_EX_ADD:  v_q <= heap_rd_q.vtx;
      OP_EX_MUL:  vn_q <= vn_full[AddrBits-1:0];
      OP_RX_EDGE: ent_q <= heap_rd_q;
      OP_OUT:     out_q <= total_q;
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign total_weight_o = out_q;

endmodule
